// ===== hdl/pba_pkg.sv =====
// Shared types, constants and helpers for the paged bump allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    localparam int NUM_PAGES = 64;
    localparam int NUM_TAGS  = 256;

    localparam int SIZE_W       = 32;
    localparam int FILL_W       = 33;
    localparam int CNT_W        = 32;
    localparam int BYTES_W      = 48;
    localparam int TAG_W        = 8;
    localparam int PAGE_INDEX_W = 6;
    localparam int STATUS_W     = 2;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam int PAGE_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int TAG_DEPTH = (NUM_TAGS > (1 << TAG_W)) ? (1 << TAG_W) : NUM_TAGS;
    localparam int TAG_AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

    localparam logic [SIZE_W-1:0] PAGE_LEN_RESET = 32'd4096;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_REWIND = 1'b1;

    localparam logic REG_PAGE_LEN = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_SIZE = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_NO_ROOM   = 2'd3
    } status_t;

    typedef struct packed {
        logic              active;
        logic              rewind;
        logic              search;
        logic              placed;
        logic [SIZE_W-1:0] size;
        logic [PAGE_W-1:0] idx;
        logic [SIZE_W-1:0] offset;
    } carry_t;

    typedef struct packed {
        logic               en;
        logic [TAG_AW-1:0]  addr;
        logic [CNT_W-1:0]   cnt;
        logic [BYTES_W-1:0] bytes;
    } ledger_wr_t;

    function automatic logic [BYTES_W-1:0] sat_add48(input logic [BYTES_W-1:0] a,
                                                     input logic [SIZE_W-1:0]  b);
        logic [BYTES_W:0] s;
        s = {1'b0, a} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, b};
        return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/paged_bump_allocator_unit.sv =====
// Top level of the paged bump allocator: APB register, request control, totals.
// Depends on pba_pkg, pba_cell_chain and pba_tag_ledger.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  cfg     | in        | psel/penable/pready| paddr, pwdata, prdata (page_len)
//  s_      | in        | s_valid / s_ready  | s_op, s_alloc_size, s_tag
//  m_      | out       | m_valid / m_ready  | m_status, m_page_index, m_page_offset,
//          |           |                    | m_tag_allocs, m_tag_bytes, m_total_bytes
//
//  A request walks the page cell chain one page per cycle, then passes the result
//  and update registers before the output register; a new request is taken only
//  after the last one has committed, one request in flight at a time.
//  Reset clears all fill levels and tag totals at once, no clearing pass.
//  A stalled result holds in the output register; the next request is still
//  taken and waits for the output to free before committing.
`timescale 1ns / 1ps
`default_nettype none

module paged_bump_allocator_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pba_pkg::APB_AW-1:0]       paddr,
    input  wire logic [pba_pkg::APB_DW-1:0]       pwdata,
    output logic      [pba_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_op,
    input  wire logic [pba_pkg::SIZE_W-1:0]       s_alloc_size,
    input  wire logic [pba_pkg::TAG_W-1:0]        s_tag,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [pba_pkg::STATUS_W-1:0]     m_status,
    output logic      [pba_pkg::PAGE_INDEX_W-1:0] m_page_index,
    output logic      [pba_pkg::SIZE_W-1:0]       m_page_offset,
    output logic      [pba_pkg::CNT_W-1:0]        m_tag_allocs,
    output logic      [pba_pkg::BYTES_W-1:0]      m_tag_bytes,
    output logic      [pba_pkg::BYTES_W-1:0]      m_total_bytes
);
    import pba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_CALC = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] page_len_reg;
    logic              accept;
    logic              commit;
    logic              search;
    status_t           pre_status;
    carry_t            chain_in, chain_out;
    ledger_wr_t        led_wr;
    logic [CNT_W-1:0]   led_cnt;
    logic [BYTES_W-1:0] led_bytes;

    status_t            item_status_reg;
    logic               item_search_reg;
    logic               item_tag_ok_reg;
    logic [TAG_AW-1:0]  item_tag_reg;
    logic [SIZE_W-1:0]  item_size_reg;
    logic               res_placed_reg;
    logic [PAGE_W-1:0]  res_idx_reg;
    logic [SIZE_W-1:0]  res_off_reg;

    logic               success;
    status_t            upd_status_next, upd_status_reg;
    logic               upd_success_reg;
    logic [PAGE_INDEX_W-1:0] upd_idx_next, upd_idx_reg;
    logic [SIZE_W-1:0]  upd_off_next, upd_off_reg;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   upd_cnt_next, upd_cnt_reg;
    logic [BYTES_W-1:0] upd_bytes_next, upd_bytes_reg;
    logic [BYTES_W-1:0] upd_total_next, upd_total_reg;
    logic [BYTES_W-1:0] grand_total_reg;

    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg;
    logic [PAGE_INDEX_W-1:0] m_page_index_reg;
    logic [SIZE_W-1:0]       m_page_offset_reg;
    logic [CNT_W-1:0]        m_tag_allocs_reg;
    logic [BYTES_W-1:0]      m_tag_bytes_reg;
    logic [BYTES_W-1:0]      m_total_bytes_reg;

    // register port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_len_reg <= PAGE_LEN_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_PAGE_LEN) begin
            page_len_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PAGE_LEN) ? page_len_reg : '0;

    // request entry
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        search     = 1'b0;
        pre_status = ST_OK;
        if (s_op != OP_REWIND) begin
            if (s_alloc_size == '0) begin
                pre_status = ST_ZERO_SIZE;
            end else if (s_alloc_size > page_len_reg) begin
                pre_status = ST_TOO_LARGE;
            end else begin
                search = 1'b1;
            end
        end
        chain_in.active = accept;
        chain_in.rewind = (s_op == OP_REWIND);
        chain_in.search = search;
        chain_in.placed = 1'b0;
        chain_in.size   = s_alloc_size;
        chain_in.idx    = '0;
        chain_in.offset = '0;
    end

    pba_cell_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .page_len  (page_len_reg),
        .carry_in  (chain_in),
        .carry_out (chain_out)
    );

    pba_tag_ledger u_ledger (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (TAG_AW'(s_tag)),
        .wr       (led_wr),
        .rd_cnt   (led_cnt),
        .rd_bytes (led_bytes)
    );

    // totals update
    always_comb begin
        success = item_search_reg && res_placed_reg;
        if (item_status_reg != ST_OK) begin
            upd_status_next = item_status_reg;
        end else if (item_search_reg && !res_placed_reg) begin
            upd_status_next = ST_NO_ROOM;
        end else begin
            upd_status_next = ST_OK;
        end
        cnt_inc        = (led_cnt == '1) ? led_cnt : led_cnt + CNT_W'(1);
        upd_idx_next   = success ? PAGE_INDEX_W'(res_idx_reg) : '0;
        upd_off_next   = success ? res_off_reg : '0;
        upd_cnt_next   = !item_tag_ok_reg ? '0 : (success ? cnt_inc : led_cnt);
        upd_bytes_next = !item_tag_ok_reg ? '0 :
                         (success ? sat_add48(led_bytes, item_size_reg) : led_bytes);
        upd_total_next = success ? sat_add48(grand_total_reg, item_size_reg)
                                 : grand_total_reg;
    end

    assign commit = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        led_wr.en    = commit && upd_success_reg && item_tag_ok_reg;
        led_wr.addr  = item_tag_reg;
        led_wr.cnt   = upd_cnt_reg;
        led_wr.bytes = upd_bytes_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (chain_out.active) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            grand_total_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                grand_total_reg <= upd_total_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_status_reg <= pre_status;
            item_search_reg <= search;
            item_tag_ok_reg <= (32'(s_tag) < NUM_TAGS);
            item_tag_reg    <= TAG_AW'(s_tag);
            item_size_reg   <= s_alloc_size;
        end
        if (state_reg == S_WALK && chain_out.active) begin
            res_placed_reg <= chain_out.placed;
            res_idx_reg    <= chain_out.idx;
            res_off_reg    <= chain_out.offset;
        end
        if (state_reg == S_CALC) begin
            upd_status_reg  <= upd_status_next;
            upd_success_reg <= success;
            upd_idx_reg     <= upd_idx_next;
            upd_off_reg     <= upd_off_next;
            upd_cnt_reg     <= upd_cnt_next;
            upd_bytes_reg   <= upd_bytes_next;
            upd_total_reg   <= upd_total_next;
        end
        if (commit) begin
            m_status_reg      <= upd_status_reg;
            m_page_index_reg  <= upd_idx_reg;
            m_page_offset_reg <= upd_off_reg;
            m_tag_allocs_reg  <= upd_cnt_reg;
            m_tag_bytes_reg   <= upd_bytes_reg;
            m_total_bytes_reg <= upd_total_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_page_index  = m_page_index_reg;
    assign m_page_offset = m_page_offset_reg;
    assign m_tag_allocs  = m_tag_allocs_reg;
    assign m_tag_bytes   = m_tag_bytes_reg;
    assign m_total_bytes = m_total_bytes_reg;

endmodule

`default_nettype wire

// ===== hdl/pba_page_cell.sv =====
// One page cell: holds the page's fill level, places a passing request and clears the level on a rewind.
// Depends on pba_pkg for the carry type and widths.
`timescale 1ns / 1ps
`default_nettype none

module pba_page_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [pba_pkg::SIZE_W-1:0] page_len,
    input  wire logic [pba_pkg::PAGE_W-1:0] cell_idx,
    input  wire pba_pkg::carry_t            carry_i,
    output pba_pkg::carry_t                 carry_o
);
    import pba_pkg::*;

    logic [FILL_W-1:0] fill_reg, fill_next;
    carry_t            carry_reg, carry_next;
    logic [FILL_W:0]   sum;
    logic              fits;

    always_comb begin
        sum  = {1'b0, fill_reg} + {{(FILL_W + 1 - SIZE_W){1'b0}}, carry_i.size};
        fits = (sum <= {{(FILL_W + 1 - SIZE_W){1'b0}}, page_len});
        carry_next = carry_i;
        fill_next  = fill_reg;
        if (carry_i.active) begin
            if (carry_i.rewind) begin
                fill_next = '0;
            end else if (carry_i.search && !carry_i.placed && fits) begin
                carry_next.placed = 1'b1;
                carry_next.idx    = cell_idx;
                carry_next.offset = fill_reg[SIZE_W-1:0];
                fill_next         = sum[FILL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg         <= '0;
            carry_reg.active <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            carry_reg <= carry_next;
        end
    end

    assign carry_o = carry_reg;

endmodule

`default_nettype wire

// ===== hdl/pba_cell_chain.sv =====
// Row of page cells; a request advances one page per cycle, first fit wins.
// Depends on pba_pkg and pba_page_cell.
`timescale 1ns / 1ps
`default_nettype none

module pba_cell_chain (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [pba_pkg::SIZE_W-1:0] page_len,
    input  wire pba_pkg::carry_t            carry_in,
    output pba_pkg::carry_t                 carry_out
);
    import pba_pkg::*;

    carry_t link [NUM_PAGES+1];

    assign link[0] = carry_in;

    for (genvar i = 0; i < NUM_PAGES; i++) begin : g_cell
        pba_page_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .page_len  (page_len),
            .cell_idx  (PAGE_W'(i)),
            .carry_i   (link[i]),
            .carry_o   (link[i+1])
        );
    end

    assign carry_out = link[NUM_PAGES];

endmodule

`default_nettype wire

// ===== hdl/pba_tag_ledger.sv =====
// Per-tag totals: allocation counts and byte sums in two memories.
// Depends on pba_pkg; entries read as zero until first written.
`timescale 1ns / 1ps
`default_nettype none

module pba_tag_ledger (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [pba_pkg::TAG_AW-1:0]  rd_addr,
    input  wire pba_pkg::ledger_wr_t         wr,
    output logic      [pba_pkg::CNT_W-1:0]   rd_cnt,
    output logic      [pba_pkg::BYTES_W-1:0] rd_bytes
);
    import pba_pkg::*;

    logic [CNT_W-1:0]   cnt_mem   [TAG_DEPTH];
    logic [BYTES_W-1:0] bytes_mem [TAG_DEPTH];
    logic [TAG_DEPTH-1:0] vld_reg;
    logic [CNT_W-1:0]   cnt_rd_reg;
    logic [BYTES_W-1:0] bytes_rd_reg;
    logic               rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            cnt_mem[wr.addr]   <= wr.cnt;
            bytes_mem[wr.addr] <= wr.bytes;
        end
        if (rd_en) begin
            cnt_rd_reg   <= cnt_mem[rd_addr];
            bytes_rd_reg <= bytes_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_cnt   = rd_vld_reg ? cnt_rd_reg   : '0;
    assign rd_bytes = rd_vld_reg ? bytes_rd_reg : '0;

endmodule

`default_nettype wire

// ===== hdl/pba_checker.sv =====
// Port-level checks for paged_bump_allocator_unit, bound to the top level.
// Depends on pba_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module pba_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [pba_pkg::STATUS_W-1:0]     m_status,
    input wire logic [pba_pkg::PAGE_INDEX_W-1:0] m_page_index,
    input wire logic [pba_pkg::SIZE_W-1:0]       m_page_offset,
    input wire logic [pba_pkg::CNT_W-1:0]        m_tag_allocs,
    input wire logic [pba_pkg::BYTES_W-1:0]      m_tag_bytes,
    input wire logic [pba_pkg::BYTES_W-1:0]      m_total_bytes
);
    import pba_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_page_index)
            && $stable(m_page_offset) && $stable(m_tag_allocs)
            && $stable(m_tag_bytes) && $stable(m_total_bytes))
        else $error("stalled result changed");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_fail_no_place: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_page_index == '0) && (m_page_offset == '0))
        else $error("failed request reports a placement");

    a_totals_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tag_bytes >= {{(BYTES_W - CNT_W){1'b0}}, m_tag_allocs})
            && (m_total_bytes >= m_tag_bytes))
        else $error("totals out of order");

endmodule

bind paged_bump_allocator_unit pba_checker u_pba_checker (.*);

`default_nettype wire

// ===== tb/paged_bump_allocator_unit_tb.sv =====
// Self-checking testbench for paged_bump_allocator_unit: drives allocate and rewind requests,
// programs the page length over APB, and checks every result against an in-bench arena model.
// Depends on pba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module paged_bump_allocator_unit_tb;
    import pba_pkg::*;

    localparam int                CLK_HALF       = 6;
    localparam int                SETTLE_CYCLES  = NUM_PAGES + 8;
    localparam int                LONG_HOLD      = 500;
    localparam int                WATCHDOG_LIMIT = 3000;
    localparam logic [APB_AW-1:0] PAGE_LEN_ADDR  = {REG_PAGE_LEN, 2'b00};
    localparam logic [47:0]       BYTES_CAP      = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0]       COUNT_CAP      = 32'hFFFF_FFFF;

    typedef struct {
        status_t                   status;
        logic [PAGE_INDEX_W-1:0]   page_index;
        logic [SIZE_W-1:0]         page_offset;
        logic [CNT_W-1:0]          tag_allocs;
        logic [BYTES_W-1:0]        tag_bytes;
        logic [BYTES_W-1:0]        total_bytes;
    } alloc_result_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_op;
    logic [SIZE_W-1:0]         s_alloc_size;
    logic [TAG_W-1:0]          s_tag;
    logic                      m_valid;
    logic                      m_ready;
    logic [STATUS_W-1:0]       m_status;
    logic [PAGE_INDEX_W-1:0]   m_page_index;
    logic [SIZE_W-1:0]         m_page_offset;
    logic [CNT_W-1:0]          m_tag_allocs;
    logic [BYTES_W-1:0]        m_tag_bytes;
    logic [BYTES_W-1:0]        m_total_bytes;

    // arena model state
    logic [SIZE_W-1:0]         arena_page_len;
    logic [FILL_W-1:0]         fill_level [NUM_PAGES];
    logic [CNT_W-1:0]          tag_alloc_count [NUM_TAGS];
    logic [BYTES_W-1:0]        tag_byte_sum [NUM_TAGS];
    logic [BYTES_W-1:0]        arena_bytes;

    alloc_result_t             expected_allocs [$];
    alloc_result_t             oldest;
    logic [TAG_W-1:0]          hot_tags [4];

    int                        err_cnt;
    int                        requests_sent;
    int                        results_checked;
    int                        settings_used;
    int                        status_seen [4];
    int                        quiet_cycles;
    bit                        idle_on;
    bit                        long_hold_req;

    paged_bump_allocator_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_alloc_size  (s_alloc_size),
        .s_tag         (s_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_page_index  (m_page_index),
        .m_page_offset (m_page_offset),
        .m_tag_allocs  (m_tag_allocs),
        .m_tag_bytes   (m_tag_bytes),
        .m_total_bytes (m_total_bytes)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic logic [BYTES_W-1:0] add_capped(logic [BYTES_W-1:0] acc,
                                                      logic [SIZE_W-1:0] amount);
        if (acc > BYTES_CAP - BYTES_W'(amount))
            return BYTES_CAP;
        return acc + BYTES_W'(amount);
    endfunction

    function automatic void clear_arena_model();
        arena_page_len = PAGE_LEN_RESET;
        arena_bytes = '0;
        foreach (fill_level[i]) fill_level[i] = '0;
        foreach (tag_alloc_count[i]) tag_alloc_count[i] = '0;
        foreach (tag_byte_sum[i]) tag_byte_sum[i] = '0;
    endfunction

    function automatic alloc_result_t predict_alloc(logic op, logic [SIZE_W-1:0] bytes,
                                                    logic [TAG_W-1:0] tag_id);
        alloc_result_t r;
        int            hit;
        bit            tag_known;
        r.status      = ST_OK;
        r.page_index  = '0;
        r.page_offset = '0;
        tag_known     = int'(tag_id) < NUM_TAGS;
        if (op == OP_REWIND) begin
            foreach (fill_level[i]) fill_level[i] = '0;
        end else if (bytes == '0) begin
            r.status = ST_ZERO_SIZE;
        end else if (bytes > arena_page_len) begin
            r.status = ST_TOO_LARGE;
        end else begin
            hit = -1;
            for (int i = 0; i < NUM_PAGES && hit < 0; i++)
                if (34'(fill_level[i]) + 34'(bytes) <= 34'(arena_page_len))
                    hit = i;
            if (hit < 0) begin
                r.status = ST_NO_ROOM;
            end else begin
                r.page_index  = PAGE_INDEX_W'(hit);
                r.page_offset = fill_level[hit][SIZE_W-1:0];
                fill_level[hit] = fill_level[hit] + FILL_W'(bytes);
                arena_bytes = add_capped(arena_bytes, bytes);
                if (tag_known) begin
                    if (tag_alloc_count[tag_id] != COUNT_CAP)
                        tag_alloc_count[tag_id]++;
                    tag_byte_sum[tag_id] = add_capped(tag_byte_sum[tag_id], bytes);
                end
            end
        end
        r.tag_allocs  = tag_known ? tag_alloc_count[tag_id] : '0;
        r.tag_bytes   = tag_known ? tag_byte_sum[tag_id] : '0;
        r.total_bytes = arena_bytes;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [47:0] want_v,
                                          logic [47:0] got_v);
        if (got_v !== want_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_allocs.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, actual status %0h",
                         $time, m_status);
            end else begin
                oldest = expected_allocs.pop_front();
                compare_field("status", 48'(oldest.status), 48'(m_status));
                compare_field("page_index", 48'(oldest.page_index), 48'(m_page_index));
                compare_field("page_offset", 48'(oldest.page_offset), 48'(m_page_offset));
                compare_field("tag_allocs", 48'(oldest.tag_allocs), 48'(m_tag_allocs));
                compare_field("tag_bytes", oldest.tag_bytes, m_tag_bytes);
                compare_field("total_bytes", oldest.total_bytes, m_total_bytes);
                status_seen[oldest.status]++;
                results_checked++;
            end
        end
    end

    // result receiver with random and long stalls
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(logic op, logic [SIZE_W-1:0] bytes, logic [TAG_W-1:0] tag_id);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_alloc_size <= bytes;
        s_tag        <= tag_id;
        do @(posedge aclk); while (!s_ready);
        expected_allocs.push_back(predict_alloc(op, bytes, tag_id));
        requests_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // hold the request side until every result is back and the block is idle
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_allocs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr, logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        pwrite  <= wr;
        paddr   <= PAGE_LEN_ADDR;
        pwdata  <= wdata;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (wr)
            arena_page_len = wdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_page_len_reg();
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, '0, rd);
        compare_field("page_len", 48'(arena_page_len), 48'(rd));
    endtask

    task automatic set_page_len(logic [SIZE_W-1:0] value);
        logic [APB_DW-1:0] rd;
        settle_idle();
        apb_access(1'b1, value, rd);
        check_page_len_reg();
        settings_used++;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int         roll;
        logic [32:0] over;
        roll = $urandom_range(0, 99);
        over = {1'b0, arena_page_len} + 33'(1 + $urandom_range(0, 15));
        if (roll < 3)
            return '0;
        if (roll < 8)
            return $urandom;
        if (roll < 12)
            return over[32] ? COUNT_CAP : over[31:0];
        if (roll < 30)
            return $urandom_range(1, arena_page_len);
        return $urandom_range(1, (arena_page_len > 1) ? arena_page_len / 2 : 1);
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 9) < 7)
            return hot_tags[$urandom_range(0, 3)];
        return TAG_W'($urandom_range(0, 255));
    endfunction

    task automatic run_random(int count, int rewind_permille, bit allow_idle);
        logic op;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
                foreach (hot_tags[k]) hot_tags[k] = TAG_W'($urandom_range(0, 255));
            end
            op = ($urandom_range(0, 999) < rewind_permille) ? OP_REWIND : OP_ALLOC;
            send_request(op, pick_size(), pick_tag());
        end
    endtask

    task automatic test_reset_defaults();
        idle_on = 1'b1;
        check_page_len_reg();
        send_request(OP_ALLOC, 32'd0, 8'h00);
        send_request(OP_ALLOC, 32'd4097, 8'h01);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 8'hFF);
        send_request(OP_ALLOC, 32'd4096, 8'hFF);
        send_request(OP_ALLOC, 32'd1, 8'h80);
        send_request(OP_ALLOC, 32'd4095, 8'h80);
        send_request(OP_ALLOC, 32'd1, 8'h01);
        send_request(OP_REWIND, 32'hFFFF_FFFF, 8'h80);
        send_request(OP_ALLOC, 32'd2048, 8'h7F);
        send_request(OP_ALLOC, 32'd2048, 8'h80);
    endtask

    task automatic test_zero_page_len();
        set_page_len(32'd0);
        send_request(OP_ALLOC, 32'd1, 8'h03);
        send_request(OP_ALLOC, 32'd0, 8'h03);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 8'h03);
        send_request(OP_REWIND, 32'd0, 8'h03);
    endtask

    task automatic test_shrunk_page();
        set_page_len(32'd4096);
        send_request(OP_REWIND, 32'd0, 8'h00);
        send_request(OP_ALLOC, 32'd3000, 8'h05);
        set_page_len(32'd2000);
        send_request(OP_ALLOC, 32'd100, 8'h05);
        send_request(OP_ALLOC, 32'd2000, 8'h05);
        send_request(OP_ALLOC, 32'd1900, 8'h06);
        set_page_len(32'd1);
        send_request(OP_ALLOC, 32'd1, 8'h06);
        send_request(OP_ALLOC, 32'd2, 8'h06);
    endtask

    task automatic test_arena_full();
        set_page_len(32'hFFFF_FFFF);
        send_request(OP_REWIND, $urandom, TAG_W'($urandom_range(0, 255)));
        for (int i = 0; i < 70; i++)
            send_request(OP_ALLOC, (i % 8 == 0) ? 32'hFFFF_FFFF :
                         $urandom_range(32'h8000_0000, 32'hFFFF_FFFF),
                         TAG_W'($urandom_range(0, 255)));
    endtask

    task automatic test_long_stall();
        set_page_len(32'd4096);
        long_hold_req = 1'b1;
        run_random(250, 5, 1'b1);
    endtask

    task automatic test_random_small_pages();
        set_page_len($urandom_range(16, 256));
        run_random(200, 5, 1'b1);
        set_page_len($urandom_range(1, 16));
        run_random(200, 8, 1'b1);
    endtask

    task automatic test_random_wide();
        set_page_len($urandom | 32'h8000_0000);
        run_random(200, 5, 1'b1);
    endtask

    task automatic test_final_burst();
        set_page_len(32'd4096);
        run_random(250, 5, 1'b0);
        idle_on = 1'b0;
    endtask

    initial begin
        err_cnt         = 0;
        requests_sent   = 0;
        results_checked = 0;
        settings_used   = 0;
        status_seen     = '{default: 0};
        idle_on         = 1'b0;
        long_hold_req   = 1'b0;
        foreach (hot_tags[k]) hot_tags[k] = '0;
        clear_arena_model();
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_op         = OP_ALLOC;
        s_alloc_size = '0;
        s_tag        = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_zero_page_len();
        test_shrunk_page();
        test_arena_full();
        test_long_stall();
        test_random_small_pages();
        test_random_wide();
        test_final_burst();
        settle_idle();

        $display("covered %0d requests over %0d page length settings, %0d results checked",
                 requests_sent, settings_used, results_checked);
        $display("status mix: ok %0d, zero size %0d, too large %0d, no room %0d",
                 status_seen[ST_OK], status_seen[ST_ZERO_SIZE],
                 status_seen[ST_TOO_LARGE], status_seen[ST_NO_ROOM]);
        if (err_cnt == 0 && expected_allocs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", err_cnt, expected_allocs.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
